// ===== design/curve_speed_planner_assert.svh =====
// ----------------------------------------------------------------------------
// Curve speed planner assertion macros
// Shared property forms for the port checker of the speed planner.
// ----------------------------------------------------------------------------
`ifndef CURVE_SPEED_PLANNER_ASSERT_SVH
`define CURVE_SPEED_PLANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CSP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("curve_speed_planner: same-cycle property violated");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CSP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("curve_speed_planner: next-cycle property violated");

`endif

// ===== design/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// Curve speed planner package
// Widths, register indexes, reset values and the controller/datapath types.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 8;

  localparam int unsigned DivW      = 36;
  localparam int unsigned DenW      = 18;
  localparam int unsigned RemW      = 20;
  localparam int unsigned RootW     = 18;
  localparam int unsigned AccW      = 34;
  localparam int unsigned StepW     = 6;
  localparam int unsigned DivSteps  = 36;
  localparam int unsigned SqrtSteps = 18;

  localparam logic [CfgIdxW-1:0] RegTrustThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStraightSpeed  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLatAccelMax    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegCurveSpeedMin  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegCurveSpeedMax  = 8'd4;
  localparam logic [CfgIdxW-1:0] RegEntrySpeedMin  = 8'd5;
  localparam logic [CfgIdxW-1:0] RegEntrySpeedMax  = 8'd6;
  localparam logic [CfgIdxW-1:0] RegSafetyFactor   = 8'd7;

  localparam logic [WordW-1:0] TrustThresholdRst = 16'd32768;
  localparam logic [WordW-1:0] StraightSpeedRst  = 16'd1536;
  localparam logic [WordW-1:0] LatAccelMaxRst    = 16'd1256;
  localparam logic [WordW-1:0] CurveSpeedMinRst  = 16'd461;
  localparam logic [WordW-1:0] CurveSpeedMaxRst  = 16'd1280;
  localparam logic [WordW-1:0] EntrySpeedMinRst  = 16'd384;
  localparam logic [WordW-1:0] EntrySpeedMaxRst  = 16'd512;
  localparam logic [WordW-1:0] SafetyFactorRst   = 16'd42598;

  // 0.1 m in Q8.8, rounded so that the test reads offset <= 25.
  localparam logic signed [WordW-1:0] LateralLimit = 16'sd25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_CLAMP,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_MDIV_INIT,
    ST_MDIV,
    ST_FINAL,
    ST_SAFETY,
    ST_OUT
  } csp_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_SQRT_INIT,
    CMD_SQRT_STEP,
    CMD_CLAMP,
    CMD_MAC0,
    CMD_MAC1,
    CMD_MAC2,
    CMD_MDIV_INIT,
    CMD_FINAL,
    CMD_SAFETY,
    CMD_EMIT
  } csp_cmd_e;

  typedef struct packed {
    csp_cmd_e op;
    logic     curve_sel;
  } csp_cmd_t;

  typedef struct packed {
    logic speed_req;
    logic out_free;
  } csp_status_t;

  typedef struct packed {
    logic [WordW-1:0] trust_threshold;
    logic [WordW-1:0] straight_speed;
    logic [WordW-1:0] lateral_accel_max;
    logic [WordW-1:0] curve_speed_min;
    logic [WordW-1:0] curve_speed_max;
    logic [WordW-1:0] entry_speed_min;
    logic [WordW-1:0] entry_speed_max;
    logic [WordW-1:0] safety_factor;
  } csp_cfg_t;

endpackage

// ===== design/csp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Curve speed planner controller
// Sequences the shared divider, square root and multiplier of the datapath.
// ----------------------------------------------------------------------------
module csp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  csp_pkg::csp_status_t status_i,
  output csp_pkg::csp_cmd_t    cmd_o
);
  import csp_pkg::*;

  csp_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && status_i.speed_req) begin
          state_d = ST_DIV_INIT;
          pass_d  = 1'b0;
        end
      end
      ST_DIV_INIT: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_SQRT_INIT;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_SQRT_INIT: begin
        state_d = ST_SQRT;
        step_d  = '0;
      end
      ST_SQRT: begin
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = ST_CLAMP;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_CLAMP: begin
        if (pass_q) begin
          state_d = ST_MAC0;
        end else begin
          state_d = ST_DIV_INIT;
          pass_d  = 1'b1;
        end
      end
      ST_MAC0:      state_d = ST_MAC1;
      ST_MAC1:      state_d = ST_MAC2;
      ST_MAC2:      state_d = ST_MDIV_INIT;
      ST_MDIV_INIT: begin
        state_d = ST_MDIV;
        step_d  = '0;
      end
      ST_MDIV: begin
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_FINAL;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_FINAL:  state_d = ST_SAFETY;
      ST_SAFETY: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o       = 1'b0;
    cmd_o.op        = CMD_NONE;
    cmd_o.curve_sel = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.op = CMD_LOAD;
        end
      end
      ST_DIV_INIT:  cmd_o.op = CMD_DIV_INIT;
      ST_DIV:       cmd_o.op = CMD_DIV_STEP;
      ST_SQRT_INIT: cmd_o.op = CMD_SQRT_INIT;
      ST_SQRT:      cmd_o.op = CMD_SQRT_STEP;
      ST_CLAMP:     cmd_o.op = CMD_CLAMP;
      ST_MAC0:      cmd_o.op = CMD_MAC0;
      ST_MAC1:      cmd_o.op = CMD_MAC1;
      ST_MAC2:      cmd_o.op = CMD_MAC2;
      ST_MDIV_INIT: cmd_o.op = CMD_MDIV_INIT;
      ST_MDIV:      cmd_o.op = CMD_DIV_STEP;
      ST_FINAL:     cmd_o.op = CMD_FINAL;
      ST_SAFETY:    cmd_o.op = CMD_SAFETY;
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = CMD_EMIT;
        end
      end
      default: cmd_o.op = CMD_NONE;
    endcase
  end

endmodule

// ===== design/csp_dpath.sv =====
// ----------------------------------------------------------------------------
// Curve speed planner datapath
// Obstacle flag, radix-2 divider, digit square root, multiplier and output.
// ----------------------------------------------------------------------------
module csp_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  csp_pkg::csp_cmd_t            cmd_i,
  output csp_pkg::csp_status_t         status_o,
  input  csp_pkg::csp_cfg_t            cfg_i,
  input  logic                         in_user_i,
  input  logic [csp_pkg::InDataW-1:0]  in_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [csp_pkg::OutDataW-1:0] out_data_o
);
  import csp_pkg::*;

  logic                     in_is_obst;
  logic signed [WordW-1:0]  in_lat;
  logic [WordW-1:0]         in_trust;
  logic                     hit;

  logic [WordW-1:0]    ecurv_q, ecurv_d, ccurv_q, ccurv_d;
  logic [WordW-1:0]    ps_q, ps_d, pe_q, pe_d, pc_q, pc_d;
  logic                flag_q, flag_d;
  logic [DenW-1:0]     den_q, den_d;
  logic [DivW-1:0]     dq_q, dq_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [WordW-1:0]    v_entry_q, v_entry_d, v_curve_q, v_curve_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic                nop_q, nop_d;
  logic [WordW-1:0]    speed_q, speed_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_valid_q, out_valid_d;

  logic [WordW-1:0]   sel_curv, curv_mag, lo, hi, clamped;
  logic [RootW-1:0]   root_lo;
  logic [RemW-1:0]    rem_sh, div_diff, srem, trial, sq_diff;
  logic               div_ge, sq_ge;
  logic [WordW-1:0]   mul_a, mul_b;
  logic [2*WordW-1:0] product;
  logic [DenW-1:0]    psum;
  logic [WordW-1:0]   mean, capped, floored;

  assign in_is_obst = in_data_i[0];
  assign in_lat     = in_data_i[16:1];
  assign in_trust   = in_data_i[32:17];
  assign hit        = in_is_obst && (in_lat <= LateralLimit) &&
                      (in_trust > cfg_i.trust_threshold);

  assign status_o.speed_req = in_user_i;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign sel_curv = cmd_i.curve_sel ? ccurv_q : ecurv_q;
  assign curv_mag = sel_curv[WordW-1] ? (~sel_curv + WordW'(1)) : sel_curv;
  assign lo       = cmd_i.curve_sel ? cfg_i.curve_speed_min : cfg_i.entry_speed_min;
  assign hi       = cmd_i.curve_sel ? cfg_i.curve_speed_max : cfg_i.entry_speed_max;
  assign root_lo  = (root_q < RootW'(lo)) ? RootW'(lo) : root_q;
  assign clamped  = (sel_curv == '0) ? hi :
                    (root_lo > RootW'(hi)) ? hi : root_lo[WordW-1:0];

  assign rem_sh   = {rem_q[RemW-2:0], dq_q[DivW-1]};
  assign div_ge   = rem_sh >= RemW'(den_q);
  assign div_diff = rem_sh - RemW'(den_q);

  assign srem    = {rem_q[RemW-3:0], dq_q[DivW-1:DivW-2]};
  assign trial   = {root_q, 2'b01};
  assign sq_ge   = srem >= trial;
  assign sq_diff = srem - trial;

  always_comb begin
    case (cmd_i.op)
      CMD_MAC0: begin
        mul_a = ps_q;
        mul_b = cfg_i.straight_speed;
      end
      CMD_MAC1: begin
        mul_a = pe_q;
        mul_b = v_entry_q;
      end
      CMD_MAC2: begin
        mul_a = pc_q;
        mul_b = v_curve_q;
      end
      default: begin
        mul_a = speed_q;
        mul_b = cfg_i.safety_factor;
      end
    endcase
  end

  assign product = (2*WordW)'(mul_a) * (2*WordW)'(mul_b);
  assign psum    = DenW'(ps_q) + DenW'(pe_q) + DenW'(pc_q);
  assign mean    = nop_q ? cfg_i.straight_speed : dq_q[WordW-1:0];
  assign capped  = (mean > cfg_i.straight_speed) ? cfg_i.straight_speed : mean;
  assign floored = (capped < cfg_i.curve_speed_min) ? cfg_i.curve_speed_min : capped;

  always_comb begin
    ecurv_d     = ecurv_q;
    ccurv_d     = ccurv_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    pc_d        = pc_q;
    flag_d      = flag_q;
    den_d       = den_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    root_d      = root_q;
    v_entry_d   = v_entry_q;
    v_curve_d   = v_curve_q;
    acc_d       = acc_q;
    nop_d       = nop_q;
    speed_d     = speed_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      CMD_NONE: ;
      CMD_LOAD: begin
        ecurv_d = in_data_i[48:33];
        ccurv_d = in_data_i[64:49];
        ps_d    = in_data_i[80:65];
        pe_d    = in_data_i[96:81];
        pc_d    = in_data_i[112:97];
        if (!in_user_i && hit) begin
          flag_d = 1'b1;
        end
      end
      CMD_DIV_INIT: begin
        den_d = DenW'(curv_mag);
        dq_d  = {cfg_i.lateral_accel_max, 20'd0};
        rem_d = '0;
      end
      CMD_DIV_STEP: begin
        rem_d = div_ge ? div_diff : rem_sh;
        dq_d  = {dq_q[DivW-2:0], div_ge};
      end
      CMD_SQRT_INIT: begin
        rem_d  = '0;
        root_d = '0;
      end
      CMD_SQRT_STEP: begin
        rem_d  = sq_ge ? sq_diff : srem;
        root_d = {root_q[RootW-2:0], sq_ge};
        dq_d   = {dq_q[DivW-3:0], 2'b00};
      end
      CMD_CLAMP: begin
        if (cmd_i.curve_sel) begin
          v_curve_d = clamped;
        end else begin
          v_entry_d = clamped;
        end
      end
      CMD_MAC0: acc_d = AccW'(product);
      CMD_MAC1: acc_d = acc_q + AccW'(product);
      CMD_MAC2: acc_d = acc_q + AccW'(product);
      CMD_MDIV_INIT: begin
        den_d = psum;
        dq_d  = DivW'(acc_q);
        rem_d = '0;
        nop_d = (psum == '0);
      end
      CMD_FINAL: speed_d = floored;
      CMD_SAFETY: begin
        if (flag_q) begin
          speed_d = product[2*WordW-1:WordW];
        end
      end
      CMD_EMIT: begin
        out_data_d  = {6'd0, nop_q, flag_q, speed_q};
        out_valid_d = 1'b1;
        flag_d      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ecurv_q    <= ecurv_d;
    ccurv_q    <= ccurv_d;
    ps_q       <= ps_d;
    pe_q       <= pe_d;
    pc_q       <= pc_d;
    den_q      <= den_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    v_entry_q  <= v_entry_d;
    v_curve_q  <= v_curve_d;
    acc_q      <= acc_d;
    nop_q      <= nop_d;
    speed_q    <= speed_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/curve_speed_planner.sv =====
// ----------------------------------------------------------------------------
// Curve speed planner
// Plans a target speed from obstacle reports and road-state probabilities.
// ----------------------------------------------------------------------------
// An obstacle report (tuser 0) yields no output, so reports can stream at one
// per cycle while no speed request is in progress. A speed request (tuser 1)
// has its result placed on the output register, and the next transaction can
// be taken in the same cycle as that result appears. Requests are spaced by
// their processing in the shared one-bit-per-cycle divider, which runs 36
// steps for each curvature quotient and for the weighted mean, and in the
// 18-step square root run once per curvature. While the output register
// still holds an unaccepted result, a finished request waits and the input
// stays stalled. The output register holds a finished result while new
// obstacle reports are accepted. Configuration writes are taken every cycle.
module curve_speed_planner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // is_obstacle, lateral_offset, trust_level, entry_curvature,
  // curve_curvature, prob_straight, prob_entry, prob_curve, zero fill
  input  logic [csp_pkg::InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // target_speed, obstacle_seen, no_probability, zero fill
  output logic [csp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csp_pkg::WordW-1:0]    cfg_data_i
);
  import csp_pkg::*;

  csp_cfg_t    cfg_q, cfg_d;
  csp_cmd_t    cmd;
  csp_status_t status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTrustThreshold: cfg_d.trust_threshold   = cfg_data_i;
        RegStraightSpeed:  cfg_d.straight_speed    = cfg_data_i;
        RegLatAccelMax:    cfg_d.lateral_accel_max = cfg_data_i;
        RegCurveSpeedMin:  cfg_d.curve_speed_min   = cfg_data_i;
        RegCurveSpeedMax:  cfg_d.curve_speed_max   = cfg_data_i;
        RegEntrySpeedMin:  cfg_d.entry_speed_min   = cfg_data_i;
        RegEntrySpeedMax:  cfg_d.entry_speed_max   = cfg_data_i;
        RegSafetyFactor:   cfg_d.safety_factor     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trust_threshold   <= TrustThresholdRst;
      cfg_q.straight_speed    <= StraightSpeedRst;
      cfg_q.lateral_accel_max <= LatAccelMaxRst;
      cfg_q.curve_speed_min   <= CurveSpeedMinRst;
      cfg_q.curve_speed_max   <= CurveSpeedMaxRst;
      cfg_q.entry_speed_min   <= EntrySpeedMinRst;
      cfg_q.entry_speed_max   <= EntrySpeedMaxRst;
      cfg_q.safety_factor     <= SafetyFactorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  csp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  csp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg_q),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== design/csp_checker.sv =====
// ----------------------------------------------------------------------------
// Curve speed planner port checker
// Port-level properties of the planner, bound to the top level.
// ----------------------------------------------------------------------------
`include "curve_speed_planner_assert.svh"

module csp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [csp_pkg::OutDataW-1:0] m_axis_tdata
);
  import csp_pkg::*;

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  `CSP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CSP_ASSERT_NXT(a_busy_after_req, s_acc && s_axis_tuser, !s_axis_tready)
  `CSP_ASSERT_NXT(a_report_silent, s_acc && !s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid)
  `CSP_ASSERT_IMP(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind curve_speed_planner csp_checker u_csp_checker (.*);
